// ----- design/access_frequency_max_heap_assert.svh -----
// Assertion macros for the access frequency heap
`ifndef ACCESS_FREQUENCY_MAX_HEAP_ASSERT_SVH
`define ACCESS_FREQUENCY_MAX_HEAP_ASSERT_SVH

// check an implication on every clock edge out of reset
`define AFMH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("access_frequency_max_heap: implication check failed");

// check an implication on the cycle after the antecedent
`define AFMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("access_frequency_max_heap: next-cycle check failed");

`endif

// ----- design/afmh_pkg.sv -----
// Shared constants and types for the access frequency heap
package afmh_pkg;
  localparam int KEYS    = 64;
  localparam int KEY_W   = 6;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = $clog2(KEYS);
  localparam int SIZE_W  = SLOT_W + 1;
  localparam int TOPN_W  = 7;
  localparam int FUNC_W  = 2;
  localparam int ENTRY_W = KEY_W + COUNT_W;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACCESS = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_TOP    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_WAIT,
    S_SLOT_WAIT,
    S_SIFT,
    S_SIFT_CMP,
    S_SCAN,
    S_SCAN_CMP,
    S_OUT
  } state_t;
endpackage

// ----- design/afmh_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module afmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/access_frequency_max_heap.sv -----
// Access frequency counter kept as an indexed binary max-heap
// Access: a known key first reads the pos RAM, then the slot RAM; then one compare per heap level climbed (up to 6).
// Query: result read via the pos RAM, then the slot RAM; a key never accessed is output at once with count 0.
// Top-N: one heap scan per entry over the slot RAM, reading and comparing each slot in turn.
// One item at a time; s_tready is low until the item is finished, for a result until its last result is taken.
// rst (synchronous) empties the heap and clears all key marks at once.
module access_frequency_max_heap
  import afmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // func[1:0], key[7:2], top_n[14:8]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // out_key[5:0], out_count[37:6]
  output logic              m_tuser,   // out_kind
  output logic              m_tlast
);
  state_t state, state_next;
  func_t  cur_func, cur_func_next;
  logic [KEY_W-1:0]   cur_key, cur_key_next;
  logic [COUNT_W-1:0] cur_cnt, cur_cnt_next;
  logic [SLOT_W-1:0]  pos, pos_next;
  logic [SIZE_W-1:0]  size, size_next;
  logic [TOPN_W-1:0]  want, want_next, sent, sent_next;
  logic [SIZE_W-1:0]  idx, idx_next;
  logic               best_valid, best_valid_next;
  logic [KEY_W-1:0]   best_key, best_key_next;
  logic [COUNT_W-1:0] best_cnt, best_cnt_next;
  logic [KEYS-1:0]    present, present_next;
  logic [KEY_W-1:0]   okey, okey_next;
  logic [COUNT_W-1:0] ocnt, ocnt_next;
  logic               okind, okind_next, olast, olast_next;

  logic               slot_we, pos_we;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr, pos_waddr, pos_raddr;
  logic [ENTRY_W-1:0] slot_wdata, slot_rdata;
  logic [SLOT_W-1:0]  pos_wdata, pos_rdata;

  func_t              in_func;
  logic [KEY_W-1:0]   in_key;
  logic [TOPN_W-1:0]  in_top;
  logic [KEY_W-1:0]   rd_key;
  logic [COUNT_W-1:0] rd_cnt;
  logic [SLOT_W-1:0]  parent;

  assign in_func = func_t'(s_tdata[1:0]);
  assign in_key  = s_tdata[7:2];
  assign in_top  = s_tdata[14:8];
  assign rd_key  = slot_rdata[ENTRY_W-1:COUNT_W];
  assign rd_cnt  = slot_rdata[COUNT_W-1:0];
  assign parent  = (pos - SLOT_W'(1)) >> 1;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {{(OUT_W-ENTRY_W){1'b0}}, ocnt, okey};
  assign m_tuser  = okind;
  assign m_tlast  = olast;

  afmh_ram #(.WIDTH(ENTRY_W), .DEPTH(KEYS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  afmh_ram #(.WIDTH(SLOT_W), .DEPTH(KEYS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      size    <= '0;
      present <= '0;
    end else begin
      state   <= state_next;
      size    <= size_next;
      present <= present_next;
    end
    cur_func   <= cur_func_next;
    cur_key    <= cur_key_next;
    cur_cnt    <= cur_cnt_next;
    pos        <= pos_next;
    want       <= want_next;
    sent       <= sent_next;
    idx        <= idx_next;
    best_valid <= best_valid_next;
    best_key   <= best_key_next;
    best_cnt   <= best_cnt_next;
    okey       <= okey_next;
    ocnt       <= ocnt_next;
    okind      <= okind_next;
    olast      <= olast_next;
  end

  always_comb begin
    state_next      = state;
    cur_func_next   = cur_func;
    cur_key_next    = cur_key;
    cur_cnt_next    = cur_cnt;
    pos_next        = pos;
    size_next       = size;
    want_next       = want;
    sent_next       = sent;
    idx_next        = idx;
    best_valid_next = best_valid;
    best_key_next   = best_key;
    best_cnt_next   = best_cnt;
    present_next    = present;
    okey_next       = okey;
    ocnt_next       = ocnt;
    okind_next      = okind;
    olast_next      = olast;
    slot_we         = 1'b0;
    slot_waddr      = pos;
    slot_wdata      = {cur_key, cur_cnt};
    slot_raddr      = pos;
    pos_we          = 1'b0;
    pos_waddr       = cur_key;
    pos_wdata       = pos;
    pos_raddr       = in_key;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cur_func_next = in_func;
          cur_key_next  = in_key;
          case (in_func)
            FUNC_ACCESS: begin
              if (present[in_key]) begin
                state_next = S_POS_WAIT;
              end else if (size < SIZE_W'(KEYS)) begin
                cur_cnt_next          = COUNT_W'(1);
                pos_next              = size[SLOT_W-1:0];
                size_next             = size + SIZE_W'(1);
                present_next[in_key]  = 1'b1;
                state_next            = S_SIFT;
              end
            end
            FUNC_QUERY: begin
              if (present[in_key]) begin
                state_next = S_POS_WAIT;
              end else begin
                okey_next  = in_key;
                ocnt_next  = '0;
                okind_next = 1'b0;
                olast_next = 1'b1;
                state_next = S_OUT;
              end
            end
            FUNC_TOP: begin
              want_next = (in_top < TOPN_W'(size)) ? in_top : TOPN_W'(size);
              if (in_top != '0 && size != '0) begin
                sent_next       = '0;
                idx_next        = '0;
                best_valid_next = 1'b0;
                state_next      = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POS_WAIT: begin
        pos_next   = pos_rdata;
        slot_raddr = pos_rdata;
        state_next = S_SLOT_WAIT;
      end
      S_SLOT_WAIT: begin
        if (cur_func == FUNC_ACCESS) begin
          cur_cnt_next = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
          state_next   = S_SIFT;
        end else begin
          okey_next  = cur_key;
          ocnt_next  = rd_cnt;
          okind_next = 1'b0;
          olast_next = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SIFT: begin
        if (pos == '0) begin
          slot_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          slot_raddr = parent;
          state_next = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (cur_cnt > rd_cnt) begin
          slot_wdata = slot_rdata;
          pos_waddr  = rd_key;
          pos_next   = parent;
          state_next = S_SIFT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx == size) begin
          okey_next  = best_key;
          ocnt_next  = best_cnt;
          okind_next = 1'b1;
          olast_next = (sent + TOPN_W'(1) == want);
          sent_next  = sent + TOPN_W'(1);
          state_next = S_OUT;
        end else begin
          slot_raddr = idx[SLOT_W-1:0];
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if ((sent == '0 || rd_cnt < ocnt || (rd_cnt == ocnt && rd_key > okey)) &&
            (!best_valid || rd_cnt > best_cnt ||
             (rd_cnt == best_cnt && rd_key < best_key))) begin
          best_valid_next = 1'b1;
          best_key_next   = rd_key;
          best_cnt_next   = rd_cnt;
        end
        idx_next   = idx + SIZE_W'(1);
        state_next = S_SCAN;
      end
      S_OUT: begin
        if (m_tready) begin
          if (okind && sent != want) begin
            idx_next        = '0;
            best_valid_next = 1'b0;
            state_next      = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ----- design/afmh_checker.sv -----
// Port-level checks for the access frequency heap, bound to the top level
`include "access_frequency_max_heap_assert.svh"

module afmh_checker
  import afmh_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             m_tlast
);
  `AFMH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `AFMH_ASSERT_IMP(a_query_last, m_tvalid && !m_tuser, m_tlast)
  `AFMH_ASSERT_IMP(a_one_side, m_tvalid, !s_tready)
endmodule

bind access_frequency_max_heap afmh_checker u_afmh_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);

// ----- verif/afmh_checker.sv -----
// Checker for the access frequency heap: predicts results and compares them
`timescale 1ns / 100ps
module afmh_scoreboard
  import afmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,
  input  logic              m_tuser,
  input  logic              m_tlast,
  output int                fail_count,
  output int                pending
);
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               kind;
    logic               last;
  } answer_t;

  logic [KEY_W-1:0]   heap_key [KEYS];
  logic [COUNT_W-1:0] heap_cnt [KEYS];
  int                 key_slot [KEYS];
  bit                 key_seen [KEYS];
  int                 heap_fill;
  answer_t            answers_due [$];

  assign pending = answers_due.size();

  task automatic climb(input int pos);
    int par;
    logic [KEY_W-1:0] tk;
    logic [COUNT_W-1:0] tc;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (heap_cnt[pos] > heap_cnt[par]) begin
        tk = heap_key[pos]; tc = heap_cnt[pos];
        heap_key[pos] = heap_key[par]; heap_cnt[pos] = heap_cnt[par];
        heap_key[par] = tk; heap_cnt[par] = tc;
        key_slot[heap_key[pos]] = pos;
        key_slot[heap_key[par]] = par;
        pos = par;
      end else begin
        break;
      end
    end
  endtask

  task automatic apply_item(input logic [IN_W-1:0] d);
    func_t f;
    logic [KEY_W-1:0] k;
    int n, want, j;
    answer_t a;
    answer_t ranked [$];
    f = func_t'(d[1:0]);
    k = d[7:2];
    n = int'(d[14:8]);
    case (f)
      FUNC_ACCESS: begin
        if (!key_seen[k]) begin
          key_seen[k] = 1;
          heap_key[heap_fill] = k;
          heap_cnt[heap_fill] = 1;
          key_slot[k] = heap_fill;
          heap_fill++;
          climb(heap_fill - 1);
        end else begin
          if (heap_cnt[key_slot[k]] != COUNT_MAX) heap_cnt[key_slot[k]]++;
          climb(key_slot[k]);
        end
      end
      FUNC_QUERY: begin
        a.key = k;
        a.count = key_seen[k] ? heap_cnt[key_slot[k]] : '0;
        a.kind = 0;
        a.last = 1;
        answers_due = {answers_due, a};
      end
      FUNC_TOP: begin
        for (int i = 0; i < heap_fill; i++) begin
          a.key = heap_key[i]; a.count = heap_cnt[i]; a.kind = 1; a.last = 0;
          j = 0;
          while (j < ranked.size() && (ranked[j].count > a.count ||
                 (ranked[j].count == a.count && ranked[j].key < a.key))) j++;
          ranked.insert(j, a);
        end
        want = n < ranked.size() ? n : ranked.size();
        for (int i = 0; i < want; i++) begin
          a = ranked[i];
          a.last = (i == want - 1);
          answers_due = {answers_due, a};
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    answer_t got, exp_a;
    if (rst) begin
      heap_fill = 0;
      fail_count <= 0;
      answers_due.delete();
      for (int i = 0; i < KEYS; i++) key_seen[i] = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.key = m_tdata[5:0];
        got.count = m_tdata[37:6];
        got.kind = m_tuser;
        got.last = m_tlast;
        if (answers_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected item key=%0d count=%0d", got.key, got.count);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answers_due.pop_front();
          if (got != exp_a) begin
            if (fail_count < 10)
              $display({"mismatch exp key=%0d cnt=%0d kind=%0b last=%0b",
                        " got key=%0d cnt=%0d kind=%0b last=%0b"},
                       exp_a.key, exp_a.count, exp_a.kind, exp_a.last,
                       got.key, got.count, got.kind, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) apply_item(s_tdata);
    end
  end
endmodule

// ----- verif/tb_access_frequency_max_heap.sv -----
// Testbench top for the access frequency heap: stimulus, stalls and verdict
`timescale 1ns / 100ps
module tb_access_frequency_max_heap;
  import afmh_pkg::*;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  logic [3:0]       stall_phase = 0;

  localparam int CYCLE_LIMIT = 10000000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  access_frequency_max_heap uut (.*);

  afmh_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_access_frequency_max_heap NOT OK");
      $finish;
    end
  end

  // receiver: stalls on a rotating pattern with random bursts
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[3]) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send(input func_t f, input logic [5:0] k, input logic [6:0] n);
    s_tvalid <= 1;
    s_tdata <= {1'b0, n, k, f};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3);
    repeat (g) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
  endtask

  func_t      f;
  int         burst;
  logic [5:0] rk;
  logic [6:0] rn;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send(FUNC_TOP, 0, 64);
    send(FUNC_QUERY, 63, 0);
    send(FUNC_ACCESS, 0, 0);
    send(FUNC_ACCESS, 63, 127);
    send(FUNC_ACCESS, 63, 0);
    send(FUNC_ACCESS, 21, 0);
    send(FUNC_ACCESS, 42, 0);
    send(FUNC_QUERY, 63, 0);
    send(FUNC_QUERY, 0, 127);
    send(FUNC_QUERY, 5, 0);
    send(FUNC_NONE, 63, 127);
    send(FUNC_TOP, 0, 0);
    send(FUNC_TOP, 0, 1);
    send(FUNC_TOP, 0, 3);
    send(FUNC_TOP, 63, 127);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 64; i++) send(FUNC_ACCESS, i[5:0], 0);
    send(FUNC_TOP, 0, 64);
    send(FUNC_TOP, 0, 100);
    // random
    for (int i = 0; i < 120;) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, i++) begin
        case ($urandom_range(0, 19))
          0: f = FUNC_NONE;
          1, 2: f = FUNC_TOP;
          3, 4, 5, 6: f = FUNC_QUERY;
          default: f = FUNC_ACCESS;
        endcase
        if (f == FUNC_ACCESS && $urandom_range(0, 1) != 0) rk = 6'($urandom_range(0, 7));
        else rk = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0) rn = 7'($urandom_range(0, 127));
        else rn = 7'($urandom_range(0, 6));
        send(f, rk, rn);
      end
      gap();
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_access_frequency_max_heap OK");
    else $display("tb_access_frequency_max_heap NOT OK");
    $finish;
  end
endmodule
